[rtl/prbq_pkg.sv]
// ----------------------------------------------------------------------------
// prbq_pkg
// Shared types and codes for the priority ready/blocked queue scheduler.
// ----------------------------------------------------------------------------
package prbq_pkg;

    // Output field widths, fixed by the result word
    localparam int PID_OUT_W   = 8;
    localparam int LEVEL_OUT_W = 2;

    // Action codes; codes above query act as query
    typedef enum logic [3:0] {
        ACT_INS_READY    = 4'd0,
        ACT_DROP_READY   = 4'd1,
        ACT_INS_BLOCK    = 4'd2,
        ACT_POP_BLOCK    = 4'd3,
        ACT_CLEAR_RUN    = 4'd4,
        ACT_RUN_TO_READY = 4'd5,
        ACT_RUN_TO_BLOCK = 4'd6,
        ACT_READY_TO_RUN = 4'd7,
        ACT_QUERY        = 4'd8
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEVEL = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Queue select, top bit of the queue memory address
    localparam logic SEL_READY = 1'b0;
    localparam logic SEL_BLOCK = 1'b1;

    // Highest-priority running slot
    typedef struct packed {
        logic                   found;
        logic [LEVEL_OUT_W-1:0] lvl;
        logic [PID_OUT_W-1:0]   pid;
    } run_pick_t;

endpackage

[rtl/prbq_run_pick.sv]
// ----------------------------------------------------------------------------
// prbq_run_pick
// Priority pick over the running slots: the highest occupied level wins.
// ----------------------------------------------------------------------------
module prbq_run_pick #(
    parameter int LEVELS    = 3,
    parameter int PID_WIDTH = 8
) (
    input  logic [LEVELS-1:0]    slot_valid,
    input  logic [PID_WIDTH-1:0] slot_pid [LEVELS],
    output prbq_pkg::run_pick_t  pick
);
    import prbq_pkg::*;

    // Scan upward so the highest occupied level overrides the lower ones
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (slot_valid[i])
            begin
                pick.found = 1'b1;
                pick.lvl   = LEVEL_OUT_W'(i);
                pick.pid   = PID_OUT_W'(slot_pid[i]);
            end
        end
    end

endmodule

[rtl/priority_ready_block_queues.sv]
// ----------------------------------------------------------------------------
// priority_ready_block_queues
// Multilevel scheduler: per level a running slot, a ready FIFO and a blocked
// FIFO of process IDs, with all FIFO entries held in one queue memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one command word: action,
//   level and pid. Output channel (out_valid / out_stall) returns one result
//   word per command: status plus the highest-priority running ID after the
//   command took effect.
//   At acceptance the command word is registered and the synchronous read
//   of the ready head from the queue memory is launched; the commit then
//   applies the update and loads the output register. The registered memory
//   read sets this sequence; a new command is not accepted until the current
//   one has committed.
//   in_stall is high while a command is executing. A finished result sits in
//   the output register; the next command is accepted while it waits. If the
//   receiver still stalls when the following command is ready to commit,
//   that command holds in execution until the output register frees up.
//   Reset empties every FIFO and running slot at once (head and count
//   registers only); the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module priority_ready_block_queues #(
    parameter int LEVELS      = 3,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_WIDTH   = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [3:0]                            action,
    input  logic [1:0]                            level,
    input  logic [prbq_pkg::PID_OUT_W-1:0]        pid,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output prbq_pkg::status_t                     status,
    output logic [prbq_pkg::PID_OUT_W-1:0]        running_pid,
    output logic                                  running_valid,
    output logic [prbq_pkg::LEVEL_OUT_W-1:0]      running_level
);
    import prbq_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = 1 + LW + QW;
    localparam int MEM_DEPTH = 2 ** AW;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Wrap a position into the FIFO ring
    function automatic logic [QW-1:0] ring_add(input logic [QW-1:0] head,
                                               input logic [CW-1:0] count);
        logic [QW+1:0] sum;
        begin
            sum = (QW+2)'(head) + (QW+2)'(count);
            if (sum >= (QW+2)'(QUEUE_DEPTH))
                sum = sum - (QW+2)'(QUEUE_DEPTH);
            return QW'(sum);
        end
    endfunction

    function automatic logic [QW-1:0] ring_inc(input logic [QW-1:0] head);
        begin
            if (head == QW'(QUEUE_DEPTH - 1))
                return '0;
            return head + 1'b1;
        end
    endfunction

    state_t                 state_reg;
    logic                   out_valid_reg;
    status_t                status_reg;
    run_pick_t              pick_reg;
    run_pick_t              pick;

    logic [QW-1:0]          rhead_reg [LEVELS];
    logic [QW-1:0]          rhead_next [LEVELS];
    logic [CW-1:0]          rcnt_reg [LEVELS];
    logic [CW-1:0]          rcnt_next [LEVELS];
    logic [QW-1:0]          bhead_reg [LEVELS];
    logic [QW-1:0]          bhead_next [LEVELS];
    logic [CW-1:0]          bcnt_reg [LEVELS];
    logic [CW-1:0]          bcnt_next [LEVELS];
    logic [PID_WIDTH-1:0]   run_pid_reg [LEVELS];
    logic [PID_WIDTH-1:0]   run_pid_next [LEVELS];
    logic [LEVELS-1:0]      run_vld_reg;
    logic [LEVELS-1:0]      run_vld_next;

    logic [3:0]             action_reg;
    logic [LW-1:0]          lv_idx_reg;
    logic                   lv_ok_reg;
    logic [PID_WIDTH-1:0]   pid_reg;

    logic                   accept;
    logic                   commit;
    logic                   in_lv_ok;
    logic [LW-1:0]          in_lv_idx;

    logic [PID_WIDTH-1:0]   mem [MEM_DEPTH];
    logic [AW-1:0]          rd_addr;
    logic [PID_WIDTH-1:0]   rd_data_reg;
    logic                   wr_en;
    logic                   wr_sel;
    logic [PID_WIDTH-1:0]   wr_data;
    logic [AW-1:0]          wr_addr;

    status_t                st_next;
    logic [QW-1:0]          rtail;
    logic [QW-1:0]          btail;
    logic                   r_full;
    logic                   r_empty;
    logic                   b_full;

    // Handshake
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // Level check; an invalid level maps to entry zero and is never used
    assign in_lv_ok  = (32'(level) < LEVELS);
    assign in_lv_idx = in_lv_ok ? LW'(level) : '0;

    // Capture the command word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            lv_idx_reg <= in_lv_idx;
            lv_ok_reg  <= in_lv_ok;
            pid_reg    <= PID_WIDTH'(pid);
        end
    end

    // Queue memory: read the ready head on accept, write on commit
    assign rd_addr = {SEL_READY, in_lv_idx, rhead_reg[in_lv_idx]};
    assign wr_addr = {wr_sel, lv_idx_reg, (wr_sel == SEL_BLOCK) ? btail : rtail};

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= mem[rd_addr];
        if (commit && wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Execute the command against the current level
    always_comb
    begin
        rhead_next   = rhead_reg;
        rcnt_next    = rcnt_reg;
        bhead_next   = bhead_reg;
        bcnt_next    = bcnt_reg;
        run_pid_next = run_pid_reg;
        run_vld_next = run_vld_reg;
        st_next      = ST_OK;
        wr_en        = 1'b0;
        wr_sel       = SEL_READY;
        wr_data      = pid_reg;

        rtail   = ring_add(rhead_reg[lv_idx_reg], rcnt_reg[lv_idx_reg]);
        btail   = ring_add(bhead_reg[lv_idx_reg], bcnt_reg[lv_idx_reg]);
        r_full  = (rcnt_reg[lv_idx_reg] == CW'(QUEUE_DEPTH));
        r_empty = (rcnt_reg[lv_idx_reg] == '0);
        b_full  = (bcnt_reg[lv_idx_reg] == CW'(QUEUE_DEPTH));

        if (action_reg <= ACT_READY_TO_RUN && !lv_ok_reg)
            st_next = ST_BAD_LEVEL;
        else
        begin
            case (action_reg)
                ACT_INS_READY:
                begin
                    if (r_full)
                        st_next = ST_FULL;
                    else
                    begin
                        wr_en = 1'b1;
                        rcnt_next[lv_idx_reg] = rcnt_reg[lv_idx_reg] + 1'b1;
                    end
                end
                ACT_DROP_READY:
                begin
                    if (r_empty)
                        st_next = ST_EMPTY;
                    else
                    begin
                        rhead_next[lv_idx_reg] = ring_inc(rhead_reg[lv_idx_reg]);
                        rcnt_next[lv_idx_reg]  = rcnt_reg[lv_idx_reg] - 1'b1;
                    end
                end
                ACT_INS_BLOCK:
                begin
                    if (b_full)
                        st_next = ST_FULL;
                    else
                    begin
                        wr_en  = 1'b1;
                        wr_sel = SEL_BLOCK;
                        bcnt_next[lv_idx_reg] = bcnt_reg[lv_idx_reg] + 1'b1;
                    end
                end
                ACT_POP_BLOCK:
                begin
                    if (bcnt_reg[lv_idx_reg] == '0)
                        st_next = ST_EMPTY;
                    else
                    begin
                        bhead_next[lv_idx_reg] = ring_inc(bhead_reg[lv_idx_reg]);
                        bcnt_next[lv_idx_reg]  = bcnt_reg[lv_idx_reg] - 1'b1;
                    end
                end
                ACT_CLEAR_RUN:
                begin
                    if (!run_vld_reg[lv_idx_reg])
                        st_next = ST_EMPTY;
                    else
                    begin
                        run_vld_next[lv_idx_reg] = 1'b0;
                        run_pid_next[lv_idx_reg] = '0;
                    end
                end
                ACT_RUN_TO_READY:
                begin
                    if (!run_vld_reg[lv_idx_reg])
                        st_next = ST_EMPTY;
                    else if (r_full)
                        st_next = ST_FULL;
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = run_pid_reg[lv_idx_reg];
                        rcnt_next[lv_idx_reg]    = rcnt_reg[lv_idx_reg] + 1'b1;
                        run_vld_next[lv_idx_reg] = 1'b0;
                        run_pid_next[lv_idx_reg] = '0;
                    end
                end
                ACT_RUN_TO_BLOCK:
                begin
                    if (!run_vld_reg[lv_idx_reg])
                        st_next = ST_EMPTY;
                    else if (b_full)
                        st_next = ST_FULL;
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_sel  = SEL_BLOCK;
                        wr_data = run_pid_reg[lv_idx_reg];
                        bcnt_next[lv_idx_reg]    = bcnt_reg[lv_idx_reg] + 1'b1;
                        run_vld_next[lv_idx_reg] = 1'b0;
                        run_pid_next[lv_idx_reg] = '0;
                    end
                end
                ACT_READY_TO_RUN:
                begin
                    if (r_empty)
                        st_next = ST_EMPTY;
                    else
                    begin
                        rhead_next[lv_idx_reg]   = ring_inc(rhead_reg[lv_idx_reg]);
                        rcnt_next[lv_idx_reg]    = rcnt_reg[lv_idx_reg] - 1'b1;
                        run_pid_next[lv_idx_reg] = rd_data_reg;
                        run_vld_next[lv_idx_reg] = 1'b1;
                    end
                end
                default:
                begin
                    st_next = ST_OK;
                end
            endcase
        end
    end

    // Pick the running ID as it stands after the command
    prbq_run_pick #(
        .LEVELS    (LEVELS),
        .PID_WIDTH (PID_WIDTH)
    ) u_run_pick (
        .slot_valid (run_vld_next),
        .slot_pid   (run_pid_next),
        .pick       (pick)
    );

    // Per-level pointers and running slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                rhead_reg[i]   <= '0;
                rcnt_reg[i]    <= '0;
                bhead_reg[i]   <= '0;
                bcnt_reg[i]    <= '0;
                run_pid_reg[i] <= '0;
            end
            run_vld_reg <= '0;
        end
        else if (commit)
        begin
            rhead_reg   <= rhead_next;
            rcnt_reg    <= rcnt_next;
            bhead_reg   <= bhead_next;
            bcnt_reg    <= bcnt_next;
            run_pid_reg <= run_pid_next;
            run_vld_reg <= run_vld_next;
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            pick_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (commit)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (commit)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= st_next;
                pick_reg      <= pick;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign running_pid   = pick_reg.pid;
    assign running_valid = pick_reg.found;
    assign running_level = pick_reg.lvl;

    // An accepted word always blocks the next cycle's input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted back to back");

    // No running process reports zero ID and level
    a_idle_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !running_valid |-> (running_pid == '0 && running_level == '0))
        else $error("empty run result carries an ID or level");

    // The reported level is a real level
    a_run_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && running_valid) |-> (32'(running_level) < LEVELS))
        else $error("running level out of range");

    // A new result only loads while a command is executing
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) && state_reg == S_IDLE |=> !out_valid)
        else $error("result appeared without a command");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-level scheduler. A queue of command
// words feeds a clocked driver; a clocked monitor compares every result word
// against a scheduler model kept here (running slots plus ready and blocked
// FIFOs per level), updated on each accepted command.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prbq_pkg::*;

    localparam int NLEV        = 3;
    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    // One command word and one result word
    typedef struct packed {
        logic [3:0] act;
        logic [1:0] lvl;
        logic [7:0] id;
    } cmd_t;

    typedef struct packed {
        status_t    st;
        logic [7:0] rpid;
        logic       rval;
        logic [1:0] rlev;
    } sched_result_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [3:0]          action        = '0;
    logic [1:0]          level         = '0;
    logic [7:0]          pid           = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    status_t             status;
    logic [7:0]          running_pid;
    logic                running_valid;
    logic [1:0]          running_level;

    cmd_t                cmd_pending[$];
    sched_result_t       sched_expect[$];
    logic                word_taken    = 1'b0;
    int                  send_idle_pct = 35;
    int                  recv_idle_pct = 82;
    bit                  hold_req      = 1'b0;
    bit                  hold_done     = 1'b0;
    int                  hold_left     = 0;
    int                  mismatches    = 0;
    int                  cycle_count   = 0;

    // Scheduler state: queue memories indexed by ready/blocked select
    logic [7:0]          q_mem  [2][NLEV][QDEPTH];
    logic [3:0]          q_head [2][NLEV];
    logic [4:0]          q_cnt  [2][NLEV];
    logic [7:0]          run_id [NLEV];
    logic                run_on [NLEV];

    priority_ready_block_queues #(
        .LEVELS      (NLEV),
        .QUEUE_DEPTH (QDEPTH),
        .PID_WIDTH   (8)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .level         (level),
        .pid           (pid),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .running_pid   (running_pid),
        .running_valid (running_valid),
        .running_level (running_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Append an ID to the tail of one level's FIFO
    function automatic status_t q_push(logic sel, int lv, logic [7:0] id);
        logic [3:0] slot;
        if (q_cnt[sel][lv] == QDEPTH)
            return ST_FULL;
        slot = q_head[sel][lv] + q_cnt[sel][lv][3:0];
        q_mem[sel][lv][slot] = id;
        q_cnt[sel][lv] = q_cnt[sel][lv] + 1'b1;
        return ST_OK;
    endfunction

    // Remove the head of one level's FIFO
    function automatic status_t q_pop(logic sel, int lv, output logic [7:0] id);
        id = '0;
        if (q_cnt[sel][lv] == 0)
            return ST_EMPTY;
        id = q_mem[sel][lv][q_head[sel][lv]];
        q_head[sel][lv] = q_head[sel][lv] + 1'b1;
        q_cnt[sel][lv] = q_cnt[sel][lv] - 1'b1;
        return ST_OK;
    endfunction

    // Apply one command and report status plus the top running ID
    function automatic sched_result_t schedule(cmd_t c);
        sched_result_t r;
        logic [7:0]    popped;
        logic          sel;
        int            lv;
        r  = '0;
        lv = c.lvl;
        if (c.act <= ACT_READY_TO_RUN && c.lvl >= NLEV)
            r.st = ST_BAD_LEVEL;
        else
        begin
            case (c.act)
                ACT_INS_READY:  r.st = q_push(SEL_READY, lv, c.id);
                ACT_DROP_READY: r.st = q_pop(SEL_READY, lv, popped);
                ACT_INS_BLOCK:  r.st = q_push(SEL_BLOCK, lv, c.id);
                ACT_POP_BLOCK:  r.st = q_pop(SEL_BLOCK, lv, popped);
                ACT_CLEAR_RUN:
                begin
                    if (!run_on[lv])
                        r.st = ST_EMPTY;
                    else
                    begin
                        run_on[lv] = 1'b0;
                        run_id[lv] = '0;
                    end
                end
                ACT_RUN_TO_READY, ACT_RUN_TO_BLOCK:
                begin
                    sel = (c.act == ACT_RUN_TO_READY) ? SEL_READY : SEL_BLOCK;
                    if (!run_on[lv])
                        r.st = ST_EMPTY;
                    else
                    begin
                        r.st = q_push(sel, lv, run_id[lv]);
                        if (r.st == ST_OK)
                        begin
                            run_on[lv] = 1'b0;
                            run_id[lv] = '0;
                        end
                    end
                end
                ACT_READY_TO_RUN:
                begin
                    r.st = q_pop(SEL_READY, lv, popped);
                    if (r.st == ST_OK)
                    begin
                        run_id[lv] = popped;
                        run_on[lv] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        // Pick the highest occupied running slot
        for (int i = NLEV - 1; i >= 0; i--)
        begin
            if (run_on[i] && !r.rval)
            begin
                r.rpid = run_id[i];
                r.rlev = 2'(i);
                r.rval = 1'b1;
            end
        end
        return r;
    endfunction

    // Predict on acceptance, check each delivered result word
    always @(posedge clk)
    begin
        sched_result_t exp_r;
        if (rst_n)
        begin
            word_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                sched_expect.insert(sched_expect.size(), schedule({action, level, pid}));
            if (out_valid && !out_stall)
            begin
                if (sched_expect.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with none expected: status %0d pid %0d",
                             $time, status, running_pid);
                end
                else
                begin
                    exp_r = sched_expect[0];
                    sched_expect.delete(0);
                    if (status !== exp_r.st)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.st, status);
                    end
                    if (running_pid !== exp_r.rpid)
                    begin
                        mismatches++;
                        $display("%0t: running_pid expected %0d actual %0d",
                                 $time, exp_r.rpid, running_pid);
                    end
                    if (running_valid !== exp_r.rval)
                    begin
                        mismatches++;
                        $display("%0t: running_valid expected %0d actual %0d",
                                 $time, exp_r.rval, running_valid);
                    end
                    if (running_level !== exp_r.rlev)
                    begin
                        mismatches++;
                        $display("%0t: running_level expected %0d actual %0d",
                                 $time, exp_r.rlev, running_level);
                    end
                end
            end
        end
    end

    // Hold an offered word until taken, then offer the next or idle
    always @(negedge clk)
    begin
        cmd_t nxt;
        logic offer;
        if (rst_n)
        begin
            offer = in_valid && !word_taken;
            if (!offer && cmd_pending.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = cmd_pending[0];
                cmd_pending.delete(0);
                action <= nxt.act;
                level  <= nxt.lvl;
                pid    <= nxt.id;
                offer  = 1'b1;
            end
            in_valid <= offer;
        end
    end

    // Stall results at random, or for a long stretch on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Abort the run once the cycle count reaches the limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("priority_ready_block_queues: mismatch");
            $finish;
        end
    end

    task automatic push_cmd(action_t a, logic [1:0] lv, logic [7:0] id);
        cmd_pending.insert(cmd_pending.size(), {logic'(a[3]), a[2:0], lv, id});
    endtask

    task automatic push_code(logic [3:0] a, logic [1:0] lv, logic [7:0] id);
        cmd_pending.insert(cmd_pending.size(), {a, lv, id});
    endtask

    // Wait until every queued word is taken and every result has come back
    task automatic wait_drained();
        while (cmd_pending.size() != 0 || in_valid || sched_expect.size() != 0)
            @(posedge clk);
    endtask

    // Queue runs of fill, drain and noise commands; fill and drain runs aim at one home level
    task automatic queue_random(int n);
        cmd_t c;
        int   kind;
        int   home;
        int   run_len;
        int   roll;
        while (n > 0)
        begin
            kind    = $urandom_range(0, 9);
            home    = $urandom_range(0, NLEV - 1);
            run_len = $urandom_range(8, 40);
            while (run_len > 0 && n > 0)
            begin
                c.id  = 8'($urandom_range(0, 255));
                c.lvl = 2'(home);
                if ($urandom_range(0, 19) == 0)
                    c.lvl = 2'($urandom_range(0, 3));
                roll = $urandom_range(0, 99);
                if (kind < 5)
                begin
                    if (roll < 40)      c.act = ACT_INS_READY;
                    else if (roll < 68) c.act = ACT_INS_BLOCK;
                    else if (roll < 80) c.act = ACT_READY_TO_RUN;
                    else if (roll < 88) c.act = ACT_RUN_TO_READY;
                    else if (roll < 96) c.act = ACT_RUN_TO_BLOCK;
                    else                c.act = ACT_QUERY;
                end
                else if (kind < 8)
                begin
                    if (roll < 25)      c.act = ACT_DROP_READY;
                    else if (roll < 50) c.act = ACT_POP_BLOCK;
                    else if (roll < 70) c.act = ACT_READY_TO_RUN;
                    else if (roll < 80) c.act = ACT_CLEAR_RUN;
                    else if (roll < 90) c.act = ACT_RUN_TO_READY;
                    else                c.act = ACT_RUN_TO_BLOCK;
                end
                else
                begin
                    c.act = 4'($urandom_range(0, 15));
                    c.lvl = 2'($urandom_range(0, 3));
                end
                cmd_pending.insert(cmd_pending.size(), c);
                run_len--;
                n--;
            end
        end
    endtask

    initial
    begin
        for (int s = 0; s < 2; s++)
            for (int l = 0; l < NLEV; l++)
            begin
                q_head[s][l] = '0;
                q_cnt[s][l]  = '0;
            end
        for (int l = 0; l < NLEV; l++)
        begin
            run_id[l] = '0;
            run_on[l] = 1'b0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty cases, bad level, overwrite on promotion, all moves
        push_cmd(ACT_QUERY,        2'd0, 8'h00);
        push_cmd(ACT_CLEAR_RUN,    2'd0, 8'h00);
        push_cmd(ACT_DROP_READY,   2'd1, 8'h00);
        push_cmd(ACT_POP_BLOCK,    2'd2, 8'h00);
        push_cmd(ACT_READY_TO_RUN, 2'd0, 8'h00);
        push_cmd(ACT_RUN_TO_READY, 2'd1, 8'h00);
        push_cmd(ACT_RUN_TO_BLOCK, 2'd2, 8'h00);
        push_cmd(ACT_INS_READY,    2'd3, 8'hff);
        push_cmd(ACT_INS_READY,    2'd0, 8'h00);
        push_cmd(ACT_INS_READY,    2'd0, 8'hff);
        push_cmd(ACT_READY_TO_RUN, 2'd0, 8'h00);
        push_cmd(ACT_READY_TO_RUN, 2'd0, 8'h00);
        push_cmd(ACT_INS_READY,    2'd1, 8'ha5);
        push_cmd(ACT_READY_TO_RUN, 2'd1, 8'h00);
        push_cmd(ACT_INS_READY,    2'd2, 8'h5a);
        push_cmd(ACT_READY_TO_RUN, 2'd2, 8'h00);
        push_cmd(ACT_RUN_TO_BLOCK, 2'd2, 8'h00);
        push_cmd(ACT_POP_BLOCK,    2'd2, 8'h00);
        push_cmd(ACT_RUN_TO_READY, 2'd1, 8'h00);
        push_cmd(ACT_DROP_READY,   2'd1, 8'h00);
        push_cmd(ACT_INS_BLOCK,    2'd3, 8'h3c);
        push_cmd(ACT_INS_BLOCK,    2'd1, 8'hff);
        push_cmd(ACT_CLEAR_RUN,    2'd0, 8'h00);
        push_cmd(ACT_QUERY,        2'd3, 8'hff);
        push_code(4'hf,            2'd3, 8'h81);
        wait_drained();

        // Random: sender idles lightly, receiver heavily
        queue_random(615);
        wait_drained();

        // Random: roles swapped
        send_idle_pct = 82;
        recv_idle_pct = 35;
        queue_random(615);
        wait_drained();

        // Random at full rate; hold results off so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(620);
        hold_req = 1'b1;
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("priority_ready_block_queues: match");
        else
            $display("priority_ready_block_queues: mismatch");
        $finish;
    end

endmodule
